// File: hdl/pctd_pkg.sv
// pctd_pkg: shared constants, node word layout and the command and status
// structs between the controller and the datapath of the code tree decoder.
// depends on nothing
package pctd_pkg;

  localparam int NODE_COUNT   = 512;
  localparam int MAX_CODE_LEN = 32;
  localparam int NODE_W       = $clog2(NODE_COUNT);
  localparam int CNT_W        = $clog2(NODE_COUNT + 1);
  localparam int CODE_W       = 32;
  localparam int IDX_W        = $clog2(CODE_W);
  localparam int LEN_W        = 6;
  localparam int SYM_W        = 16;
  localparam int LEN_LIMIT    = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

  // action codes
  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_DECODE = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_MISSING = 2'd2;
  localparam logic [1:0] ST_EMPTY   = 2'd3;

  typedef struct packed {
    logic              leaf;
    logic [SYM_W-1:0]  sym;
    logic [1:0]        present;
    logic [NODE_W-1:0] right;
    logic [NODE_W-1:0] left;
  } node_t;

  typedef struct packed {
    logic load_item;
    logic clear;
    logic ins_start;
    logic ins_alloc;
    logic ins_follow;
    logic ins_load;
    logic ins_leaf;
    logic ins_full;
    logic dec_empty;
    logic dec_fetch;
    logic dec_load;
    logic dec_missing;
    logic dec_follow;
    logic dec_leaf;
    logic dec_step;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic at_root;
    logic cur_valid;
    logic walk_done;
    logic ins_present;
    logic dec_present;
    logic leaf;
    logic out_busy;
  } sts_t;

endpackage

// File: hdl/pctd_ram.sv
// pctd_ram: generic single write port, single read port ram with registered read
// depends on nothing
module pctd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hdl/pctd_datapath.sv
// pctd_datapath: node memory, tree walk registers, decode position and output word
// depends on pctd_pkg and pctd_ram
module pctd_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [pctd_pkg::CODE_W-1:0]  code_bits,
  input  logic [pctd_pkg::LEN_W-1:0]   code_length,
  input  logic [pctd_pkg::SYM_W-1:0]   symbol,
  input  logic                         bit_req,
  input  pctd_pkg::cmd_t               cmd,
  output pctd_pkg::sts_t               sts,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic [pctd_pkg::SYM_W-1:0]   decoded_symbol,
  output logic [1:0]                   status
);

  logic [pctd_pkg::CODE_W-1:0] code_reg;
  logic [pctd_pkg::LEN_W-1:0]  len_reg;
  logic [pctd_pkg::SYM_W-1:0]  sym_reg;
  logic                        bit_reg;
  logic [pctd_pkg::LEN_W-1:0]  idx;
  logic [pctd_pkg::NODE_W-1:0] node;
  pctd_pkg::node_t             node_word;
  logic                        fresh;
  logic [pctd_pkg::CNT_W-1:0]  nodes_used;
  logic [pctd_pkg::NODE_W-1:0] current_node;
  pctd_pkg::node_t             cur_word;
  logic                        cur_valid;
  pctd_pkg::node_t             root_word;
  logic [pctd_pkg::NODE_W-1:0] child_reg;

  logic [pctd_pkg::LEN_W-1:0]  len_clip;
  logic [pctd_pkg::NODE_W-1:0] alloc_addr;
  logic                        ins_dir;
  logic [pctd_pkg::NODE_W-1:0] ins_child;
  pctd_pkg::node_t             dec_word;
  logic [pctd_pkg::NODE_W-1:0] dec_child;
  pctd_pkg::node_t             alloc_word;
  pctd_pkg::node_t             leaf_word;
  logic                        emit;

  logic                        wr_en;
  logic [pctd_pkg::NODE_W-1:0] wr_addr;
  pctd_pkg::node_t             wr_data;
  logic                        rd_en;
  logic [pctd_pkg::NODE_W-1:0] rd_addr;
  pctd_pkg::node_t             rd_data;

  assign len_clip = (code_length > pctd_pkg::LEN_W'(pctd_pkg::LEN_LIMIT))
                  ? pctd_pkg::LEN_W'(pctd_pkg::LEN_LIMIT) : code_length;
  assign alloc_addr = nodes_used[pctd_pkg::NODE_W-1:0];
  assign ins_dir    = code_reg[idx[pctd_pkg::IDX_W-1:0]];
  assign ins_child  = ins_dir ? node_word.right : node_word.left;
  assign dec_word   = (current_node == '0) ? root_word : cur_word;
  assign dec_child  = bit_reg ? dec_word.right : dec_word.left;

  always_comb begin
    alloc_word = node_word;
    if (ins_dir) begin
      alloc_word.right      = alloc_addr;
      alloc_word.present[1] = 1'b1;
    end else begin
      alloc_word.left       = alloc_addr;
      alloc_word.present[0] = 1'b1;
    end
    leaf_word      = node_word;
    leaf_word.leaf = 1'b1;
    leaf_word.sym  = sym_reg;
  end

  // one write per cycle: allocation, leaf mark, or flush of a fresh node on overflow
  always_comb begin
    wr_en   = cmd.ins_alloc | cmd.ins_leaf | (cmd.ins_full & fresh);
    wr_addr = node;
    wr_data = node_word;
    if (cmd.ins_alloc) begin
      wr_data = alloc_word;
    end else if (cmd.ins_leaf) begin
      wr_data = leaf_word;
    end
  end

  always_comb begin
    rd_en   = cmd.ins_follow | cmd.dec_fetch | cmd.dec_follow;
    rd_addr = current_node;
    if (cmd.ins_follow) begin
      rd_addr = ins_child;
    end else if (cmd.dec_follow) begin
      rd_addr = dec_child;
    end
  end

  pctd_ram #(
    .WIDTH ($bits(pctd_pkg::node_t)),
    .DEPTH (pctd_pkg::NODE_COUNT)
  ) u_node_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign emit = cmd.ins_full | cmd.dec_empty | cmd.dec_missing | cmd.dec_leaf;

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      code_reg <= code_bits;
      len_reg  <= len_clip;
      sym_reg  <= symbol;
      bit_reg  <= bit_req;
    end
    if (cmd.ins_start) begin
      node      <= '0;
      node_word <= (nodes_used == '0) ? '0 : root_word;
      fresh     <= (nodes_used == '0);
      idx       <= '0;
    end else if (cmd.ins_alloc) begin
      node      <= alloc_addr;
      node_word <= '0;
      fresh     <= 1'b1;
      idx       <= idx + 1'b1;
    end else if (cmd.ins_follow) begin
      node <= ins_child;
      idx  <= idx + 1'b1;
    end else if (cmd.ins_load) begin
      node_word <= rd_data;
      fresh     <= 1'b0;
    end
    if (cmd.dec_load || cmd.dec_step) begin
      cur_word <= rd_data;
    end
    if (cmd.dec_follow) begin
      child_reg <= dec_child;
    end
    // copy of the root node, kept in step with every write to it
    if (wr_en && (wr_addr == '0)) begin
      root_word <= wr_data;
    end
    if (emit) begin
      decoded_symbol <= cmd.dec_leaf ? rd_data.sym : '0;
      if (cmd.ins_full) begin
        status <= pctd_pkg::ST_FULL;
      end else if (cmd.dec_empty) begin
        status <= pctd_pkg::ST_EMPTY;
      end else if (cmd.dec_missing) begin
        status <= pctd_pkg::ST_MISSING;
      end else begin
        status <= pctd_pkg::ST_OK;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      nodes_used   <= '0;
      current_node <= '0;
      cur_valid    <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cmd.clear) begin
        nodes_used <= '0;
      end else if (cmd.ins_start && (nodes_used == '0)) begin
        nodes_used <= pctd_pkg::CNT_W'(1);
      end else if (cmd.ins_alloc) begin
        nodes_used <= nodes_used + 1'b1;
      end
      if (cmd.clear || emit) begin
        current_node <= '0;
      end else if (cmd.dec_step) begin
        current_node <= child_reg;
      end
      if (cmd.clear || cmd.ins_start) begin
        cur_valid <= 1'b0;
      end else if (cmd.dec_load || cmd.dec_step) begin
        cur_valid <= 1'b1;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    sts.empty       = (nodes_used == '0);
    sts.full        = (nodes_used >= pctd_pkg::CNT_W'(pctd_pkg::NODE_COUNT));
    sts.at_root     = (current_node == '0);
    sts.cur_valid   = cur_valid;
    sts.walk_done   = (idx == len_reg);
    sts.ins_present = node_word.present[ins_dir];
    sts.dec_present = dec_word.present[bit_reg];
    sts.leaf        = rd_data.leaf;
    sts.out_busy    = out_valid & ~out_ready;
  end

  a_wr_allocated: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (pctd_pkg::CNT_W'(wr_addr) < nodes_used))
    else $error("write to a node that is not allocated");

  a_alloc_room: assert property (@(posedge clk) disable iff (rst)
    cmd.ins_alloc |-> !sts.full)
    else $error("allocation with the node store full");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    nodes_used <= pctd_pkg::CNT_W'(pctd_pkg::NODE_COUNT))
    else $error("node count beyond the store size");

endmodule

// File: hdl/pctd_ctrl.sv
// pctd_ctrl: sequencer for insert walks, decode steps and clear
// depends on pctd_pkg
module pctd_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [1:0]     action,
  input  pctd_pkg::sts_t sts,
  output pctd_pkg::cmd_t cmd
);

  typedef enum logic [5:0] {
    S_IDLE      = 6'b000001,
    S_INS_STEP  = 6'b000010,
    S_INS_RD    = 6'b000100,
    S_DEC_CHECK = 6'b001000,
    S_DEC_LOAD  = 6'b010000,
    S_DEC_WAIT  = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          unique case (action)
            pctd_pkg::ACT_INSERT: begin
              cmd.ins_start = 1'b1;
              state_next    = S_INS_STEP;
            end
            pctd_pkg::ACT_DECODE: state_next = S_DEC_CHECK;
            pctd_pkg::ACT_CLEAR:  cmd.clear = 1'b1;
            default: ;
          endcase
        end
      end
      S_INS_STEP: begin
        priority if (sts.walk_done) begin
          cmd.ins_leaf = 1'b1;
          state_next   = S_IDLE;
        end else if (sts.ins_present) begin
          cmd.ins_follow = 1'b1;
          state_next     = S_INS_RD;
        end else if (sts.full) begin
          if (!sts.out_busy) begin
            cmd.ins_full = 1'b1;
            state_next   = S_IDLE;
          end
        end else begin
          cmd.ins_alloc = 1'b1;
        end
      end
      S_INS_RD: begin
        cmd.ins_load = 1'b1;
        state_next   = S_INS_STEP;
      end
      S_DEC_CHECK: begin
        priority if (sts.empty) begin
          if (!sts.out_busy) begin
            cmd.dec_empty = 1'b1;
            state_next    = S_IDLE;
          end
        end else if (!sts.at_root && !sts.cur_valid) begin
          cmd.dec_fetch = 1'b1;
          state_next    = S_DEC_LOAD;
        end else if (!sts.dec_present) begin
          if (!sts.out_busy) begin
            cmd.dec_missing = 1'b1;
            state_next      = S_IDLE;
          end
        end else begin
          cmd.dec_follow = 1'b1;
          state_next     = S_DEC_WAIT;
        end
      end
      S_DEC_LOAD: begin
        cmd.dec_load = 1'b1;
        state_next   = S_DEC_CHECK;
      end
      S_DEC_WAIT: begin
        if (sts.leaf) begin
          if (!sts.out_busy) begin
            cmd.dec_leaf = 1'b1;
            state_next   = S_IDLE;
          end
        end else begin
          cmd.dec_step = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.ins_full || cmd.dec_empty || cmd.dec_missing || cmd.dec_leaf) |-> !sts.out_busy)
    else $error("result produced while the output word is still held");

  a_ins_read: assert property (@(posedge clk) disable iff (rst)
    cmd.ins_follow |=> (state == S_INS_RD))
    else $error("insert read not followed by its load");

  // entered only from a child read, then held while the output word waits
  a_dec_read: assert property (@(posedge clk) disable iff (rst)
    (state == S_DEC_WAIT) |->
      ($past(cmd.dec_follow) || $past(state == S_DEC_WAIT)))
    else $error("decode leaf check without a child read");

endmodule

// File: hdl/prefix_code_tree_decoder.sv
// prefix_code_tree_decoder: top level of the prefix code (huffman) tree decoder
// depends on pctd_pkg, pctd_ctrl, pctd_datapath (which holds pctd_ram)
//
// usage
//   input channel (in_valid/in_ready) carries one word per action: insert a
//   code word (code_bits, first bit in bit 0, code_length, symbol), decode one
//   bit (bit_req), or clear the tree. output channel (out_valid/out_ready)
//   carries decoded_symbol and status; inserts and clears give no word unless
//   the node store overflows, decodes give a word on a leaf or an error.
//   steps, from the accept to the next accept
//   - decode: idle, branch check, child read over the single read port of
//     the node ram; an empty tree or a missing branch ends at the check. a
//     fetch and load of the current node come first when it is off the root
//     and an insert dropped its cached copy. the result word is registered
//     from the child read on a leaf, from the branch check on an error
//   - insert: idle, an allocation per new node, a read then load per
//     existing node walked, then the leaf mark; clear: idle only
//   the root node is mirrored in a register, so walks from the root start
//   without a read. reset clears the node count and the decode position;
//   no ram clearing pass is needed: each new node is written by its insert
//   a stalled receiver leaves the result in the output register; the next
//   word is accepted and worked on, and the block waits only where it must
//   deliver another result
module prefix_code_tree_decoder (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  action,
  input  logic [pctd_pkg::CODE_W-1:0] code_bits,
  input  logic [pctd_pkg::LEN_W-1:0]  code_length,
  input  logic [pctd_pkg::SYM_W-1:0]  symbol,
  input  logic                        bit_req,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [pctd_pkg::SYM_W-1:0]  decoded_symbol,
  output logic [1:0]                  status
);

  // command and status between sequencer and datapath
  pctd_pkg::cmd_t cmd;
  pctd_pkg::sts_t sts;

  pctd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .action   (action),
    .sts      (sts),
    .cmd      (cmd)
  );

  pctd_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .code_bits      (code_bits),
    .code_length    (code_length),
    .symbol         (symbol),
    .bit_req        (bit_req),
    .cmd            (cmd),
    .sts            (sts),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .decoded_symbol (decoded_symbol),
    .status         (status)
  );

endmodule

// File: sim/tb_prefix_code_tree_decoder.sv
// tb_prefix_code_tree_decoder: self-checking bench for the code tree decoder,
// a directed table then random code tables and bit streams, checked against a
// behavioral tree model or typed results; needs pctd_pkg, prefix_code_tree_decoder
module tb_prefix_code_tree_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  // action 3 has no name in the package; the block must drop it silently
  localparam logic [1:0] ACT_IGNORED = 2'd3;

  localparam int RANDOM_WORDS = 420;
  // receiver hold-off, long enough to back the block up into its input
  localparam int HOLD_CYCLES  = 400;
  // longest legal quiet spell: the hold-off plus a full-length insert walk
  // over 32 levels plus sender gaps, taken several times
  localparam int STALL_LIMIT  = 4000;
  // after the last result: covers the slowest insert that might still emit
  localparam int SETTLE_CYCLES = 80;

  typedef struct packed {
    logic [1:0]                  act;
    logic [pctd_pkg::CODE_W-1:0] code;
    logic [pctd_pkg::LEN_W-1:0]  len;
    logic [pctd_pkg::SYM_W-1:0]  sym;
    logic                        dir;
  } tree_word_t;

  typedef struct packed {
    logic [pctd_pkg::SYM_W-1:0] sym;
    logic [1:0]                 st;
  } decode_result_t;

  // directed row: reps copies, code and symbol stepping by one per copy;
  // typed rows carry their result, the rest go through the tree model
  typedef struct packed {
    logic [1:0]                  act;
    logic [pctd_pkg::CODE_W-1:0] code;
    logic [pctd_pkg::LEN_W-1:0]  len;
    logic [pctd_pkg::SYM_W-1:0]  sym;
    logic                        dir;
    logic [4:0]                  reps;
    logic                        typed;
    logic [pctd_pkg::SYM_W-1:0]  want_sym;
    logic [1:0]                  want_st;
  } script_row_t;

  script_row_t script [0:14] = '{
    // decode into an empty tree
    '{pctd_pkg::ACT_DECODE, 32'h0000_0000, 6'd0,  16'h0000, 1'b0, 5'd1,
      1'b1, 16'h0000, pctd_pkg::ST_EMPTY},
    // unknown action, every field at its top
    '{ACT_IGNORED,          32'hFFFF_FFFF, 6'd63, 16'hFFFF, 1'b1, 5'd1,
      1'b0, 16'h0000, pctd_pkg::ST_OK},
    // zero length: the root itself becomes a leaf
    '{pctd_pkg::ACT_INSERT, 32'h0000_0000, 6'd0,  16'hFFFF, 1'b0, 5'd1,
      1'b0, 16'h0000, pctd_pkg::ST_OK},
    // root has no children yet
    '{pctd_pkg::ACT_DECODE, 32'h0000_0000, 6'd0,  16'h0000, 1'b1, 5'd1,
      1'b1, 16'h0000, pctd_pkg::ST_MISSING},
    '{pctd_pkg::ACT_INSERT, 32'h0000_0001, 6'd1,  16'h0000, 1'b0, 5'd1,
      1'b0, 16'h0000, pctd_pkg::ST_OK},
    // extends below the leaf "1", which stays a leaf
    '{pctd_pkg::ACT_INSERT, 32'h0000_0001, 6'd2,  16'h1234, 1'b0, 5'd1,
      1'b0, 16'h0000, pctd_pkg::ST_OK},
    // decoding stops at leaf "1" with symbol zero
    '{pctd_pkg::ACT_DECODE, 32'h0000_0000, 6'd0,  16'h0000, 1'b1, 5'd1,
      1'b1, 16'h0000, pctd_pkg::ST_OK},
    // length over the limit, cut to 32
    '{pctd_pkg::ACT_INSERT, 32'hFFFF_FFFE, 6'd40, 16'hBEEF, 1'b0, 5'd1,
      1'b0, 16'h0000, pctd_pkg::ST_OK},
    '{pctd_pkg::ACT_DECODE, 32'h0000_0000, 6'd0,  16'h0000, 1'b0, 5'd1,
      1'b0, 16'h0000, pctd_pkg::ST_OK},
    '{pctd_pkg::ACT_CLEAR,  32'h0000_0000, 6'd0,  16'h0000, 1'b0, 5'd1,
      1'b0, 16'h0000, pctd_pkg::ST_OK},
    '{pctd_pkg::ACT_DECODE, 32'h0000_0000, 6'd0,  16'h0000, 1'b0, 5'd1,
      1'b1, 16'h0000, pctd_pkg::ST_EMPTY},
    // flood: 17 long codes splitting in the low 5 bits use 507 nodes
    '{pctd_pkg::ACT_INSERT, 32'h5A3C_9600, 6'd63, 16'h8000, 1'b0, 5'd17,
      1'b0, 16'h0000, pctd_pkg::ST_OK},
    // needs 28 more nodes, only 5 left
    '{pctd_pkg::ACT_INSERT, 32'h5A3C_9611, 6'd32, 16'h7FFF, 1'b0, 5'd1,
      1'b1, 16'h0000, pctd_pkg::ST_FULL},
    '{pctd_pkg::ACT_DECODE, 32'h0000_0000, 6'd0,  16'h0000, 1'b1, 5'd1,
      1'b0, 16'h0000, pctd_pkg::ST_OK},
    '{pctd_pkg::ACT_CLEAR,  32'h0000_0000, 6'd0,  16'h0000, 1'b0, 5'd1,
      1'b0, 16'h0000, pctd_pkg::ST_OK}
  };

  logic                          clk;
  logic                          rst;
  logic                          in_valid;
  logic                          in_ready;
  logic [1:0]                    action;
  logic [pctd_pkg::CODE_W-1:0]   code_bits;
  logic [pctd_pkg::LEN_W-1:0]    code_length;
  logic [pctd_pkg::SYM_W-1:0]    symbol;
  logic                          bit_req;
  logic                          out_valid;
  logic                          out_ready;
  logic [pctd_pkg::SYM_W-1:0]    decoded_symbol;
  logic [1:0]                    status;

  prefix_code_tree_decoder dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .action         (action),
    .code_bits      (code_bits),
    .code_length    (code_length),
    .symbol         (symbol),
    .bit_req        (bit_req),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .decoded_symbol (decoded_symbol),
    .status         (status)
  );

  // tree model state
  logic [pctd_pkg::NODE_W-1:0] kid_l    [pctd_pkg::NODE_COUNT];
  logic [pctd_pkg::NODE_W-1:0] kid_r    [pctd_pkg::NODE_COUNT];
  logic [1:0]                  kid_mask [pctd_pkg::NODE_COUNT];
  logic [pctd_pkg::SYM_W-1:0]  leaf_sym [pctd_pkg::NODE_COUNT];
  logic                        leaf_mark[pctd_pkg::NODE_COUNT];
  int unsigned                 node_total;
  logic [pctd_pkg::NODE_W-1:0] walk_pos;

  decode_result_t awaited_q[$];   // decoded words still owed by the block
  int             mismatches;

  // codes inserted since the last clear, with their effective length
  logic [pctd_pkg::CODE_W-1:0] known_code[$];
  int                          known_len[$];

  // shared between sender and receiver
  bit calm;        // no idling on either side
  bit hold_req;    // receiver holds off for HOLD_CYCLES
  bit in_random;
  int rand_words;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void blank_node(input logic [pctd_pkg::NODE_W-1:0] n);
    kid_l[n]     = '0;
    kid_r[n]     = '0;
    kid_mask[n]  = 2'b00;
    leaf_sym[n]  = '0;
    leaf_mark[n] = 1'b0;
  endfunction

  // advance the tree model by one word; returns 1 when it emits a result
  function automatic bit tree_step(input tree_word_t w, output decode_result_t r);
    logic [pctd_pkg::NODE_W-1:0] at, nxt;
    logic [1:0]                  way;
    int unsigned                 depth, i;
    r = '0;
    case (w.act)
      pctd_pkg::ACT_INSERT: begin
        depth = (w.len > pctd_pkg::LEN_LIMIT) ? pctd_pkg::LEN_LIMIT : w.len;
        if (node_total == 0) begin
          blank_node('0);
          node_total = 1;
        end
        at = '0;
        for (i = 0; i < depth; i++) begin
          way = w.code[i] ? 2'b10 : 2'b01;
          if ((kid_mask[at] & way) == 2'b00) begin
            if (node_total >= pctd_pkg::NODE_COUNT) begin
              // store full: partial path stays, no leaf, back to the root
              walk_pos = '0;
              r.st = pctd_pkg::ST_FULL;
              return 1'b1;
            end
            nxt = pctd_pkg::NODE_W'(node_total);
            blank_node(nxt);
            node_total++;
            if (w.code[i]) kid_r[at] = nxt;
            else kid_l[at] = nxt;
            kid_mask[at] = kid_mask[at] | way;
          end
          at = w.code[i] ? kid_r[at] : kid_l[at];
        end
        leaf_mark[at] = 1'b1;
        leaf_sym[at]  = w.sym;
        return 1'b0;
      end
      pctd_pkg::ACT_DECODE: begin
        way = w.dir ? 2'b10 : 2'b01;
        if (node_total == 0) begin
          walk_pos = '0;
          r.st = pctd_pkg::ST_EMPTY;
          return 1'b1;
        end
        if ((kid_mask[walk_pos] & way) == 2'b00) begin
          walk_pos = '0;
          r.st = pctd_pkg::ST_MISSING;
          return 1'b1;
        end
        nxt = w.dir ? kid_r[walk_pos] : kid_l[walk_pos];
        if (leaf_mark[nxt]) begin
          walk_pos = '0;
          r.sym = leaf_sym[nxt];
          return 1'b1;
        end
        walk_pos = nxt;
        return 1'b0;
      end
      pctd_pkg::ACT_CLEAR: begin
        node_total = 0;
        walk_pos = '0;
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t ns mismatch: %s", $time, what);
    mismatches++;
  endtask

  // every field but the action random; callers overwrite the ones that matter
  function automatic tree_word_t noise_word(input logic [1:0] act);
    tree_word_t w;
    w.act  = act;
    w.code = $urandom;
    w.len  = pctd_pkg::LEN_W'($urandom_range(0, 63));
    w.sym  = pctd_pkg::SYM_W'($urandom);
    w.dir  = 1'($urandom_range(0, 1));
    return w;
  endfunction

  function automatic void remember(input tree_word_t w);
    known_code.push_back(w.code);
    known_len.push_back((w.len > pctd_pkg::LEN_LIMIT) ? pctd_pkg::LEN_LIMIT : int'(w.len));
  endfunction

  // offer one word; entered and left at a falling edge. valid is only
  // lowered in an idle gap, so back-to-back words keep it high
  task automatic send_word(input tree_word_t w, input bit typed = 1'b0,
                           input decode_result_t want = '0);
    decode_result_t r;
    bit             has;
    while (!calm && $urandom_range(0, 99) < 29) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    action      <= w.act;
    code_bits   <= w.code;
    code_length <= w.len;
    symbol      <= w.sym;
    bit_req     <= w.dir;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    has = tree_step(w, r);
    if (typed) awaited_q.push_back(want);
    else if (has) awaited_q.push_back(r);
    if (in_random && w.act != ACT_IGNORED) rand_words++;
    calm = in_random && rand_words >= 250 && rand_words < 330;
    @(negedge clk);
  endtask

  task automatic send_clear();
    send_word(noise_word(pctd_pkg::ACT_CLEAR));
    known_code.delete();
    known_len.delete();
  endtask

  // one random round: optional clear and node store flood, a fresh prefix code
  // table, then bit streams made mostly of whole code words with some noise
  task automatic tree_episode();
    logic [pctd_pkg::CODE_W-1:0] pc_code[$];
    int                          pc_len[$];
    tree_word_t                  w;
    logic [pctd_pkg::CODE_W-1:0] c;
    int                          k, idx, pick, i;
    if ($urandom_range(0, 99) < 85) begin
      send_clear();
      // one or two decodes into the empty tree
      if ($urandom_range(0, 99) < 20)
        repeat ($urandom_range(1, 2)) send_word(noise_word(pctd_pkg::ACT_DECODE));
    end
    // now and then run the node store into overflow with long random codes
    if ($urandom_range(0, 11) == 0) begin
      repeat (20) begin
        w = noise_word(pctd_pkg::ACT_INSERT);
        w.len = pctd_pkg::LEN_W'(32);
        send_word(w);
        remember(w);
      end
    end
    // complete prefix code by random leaf splits
    pc_code = '{32'd0};
    pc_len  = '{0};
    k = $urandom_range(2, 9);
    while (pc_code.size() < k) begin
      idx = $urandom_range(0, pc_code.size() - 1);
      c = pc_code[idx] | (32'd1 << pc_len[idx]);
      pc_len[idx]++;
      pc_code.push_back(c);
      pc_len.push_back(pc_len[idx]);
    end
    // sometimes leave a hole so streams run into a missing branch
    if (k > 2 && $urandom_range(0, 99) < 25) begin
      idx = $urandom_range(0, pc_code.size() - 1);
      pc_code.delete(idx);
      pc_len.delete(idx);
    end
    while (pc_code.size() != 0) begin
      idx = $urandom_range(0, pc_code.size() - 1);
      w = noise_word(pctd_pkg::ACT_INSERT);
      // bits past the length are don't-care, keep them random
      w.code = (w.code & ~((32'd1 << pc_len[idx]) - 1)) | pc_code[idx];
      w.len  = pctd_pkg::LEN_W'(pc_len[idx]);
      send_word(w);
      remember(w);
      pc_code.delete(idx);
      pc_len.delete(idx);
    end
    if ($urandom_range(0, 99) < 30) begin
      w = noise_word(pctd_pkg::ACT_INSERT);
      send_word(w);
      remember(w);
    end
    repeat ($urandom_range(4, 14)) begin
      // keep the total close to the planned word count
      if (rand_words >= RANDOM_WORDS) break;
      pick = $urandom_range(0, 99);
      if (pick < 80 && known_code.size() != 0) begin
        idx = $urandom_range(0, known_code.size() - 1);
        for (i = 0; i < known_len[idx]; i++) begin
          w = noise_word(pctd_pkg::ACT_DECODE);
          w.dir = known_code[idx][i];
          send_word(w);
        end
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 3)) send_word(noise_word(pctd_pkg::ACT_DECODE));
      end else if (pick < 94) begin
        send_word(noise_word(ACT_IGNORED));
      end else if (pick < 98) begin
        w = noise_word(pctd_pkg::ACT_INSERT);
        send_word(w);
        remember(w);
      end else begin
        send_clear();
      end
    end
  endtask

  // stimulus and end of run
  initial begin
    tree_word_t     w;
    decode_result_t want;
    int             r, j, n;
    bit             hold_used, drain_used;
    rst         = 1'b1;
    in_valid    = 1'b0;
    action      = ACT_IGNORED;
    code_bits   = '0;
    code_length = '0;
    symbol      = '0;
    bit_req     = 1'b0;
    calm        = 1'b0;
    hold_req    = 1'b0;
    in_random   = 1'b0;
    rand_words  = 0;
    mismatches  = 0;
    hold_used   = 1'b0;
    drain_used  = 1'b0;
    for (n = 0; n < pctd_pkg::NODE_COUNT; n++) blank_node(pctd_pkg::NODE_W'(n));
    node_total = 0;
    walk_pos   = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table
    for (r = 0; r < $size(script); r++) begin
      for (j = 0; j < script[r].reps; j++) begin
        w.act    = script[r].act;
        w.code   = script[r].code + pctd_pkg::CODE_W'(j);
        w.len    = script[r].len;
        w.sym    = script[r].sym + pctd_pkg::SYM_W'(j);
        w.dir    = script[r].dir;
        want.sym = script[r].want_sym;
        want.st  = script[r].want_st;
        send_word(w, script[r].typed, want);
      end
    end
    known_code.delete();
    known_len.delete();

    // random rounds
    in_random = 1'b1;
    while (rand_words < RANDOM_WORDS) begin
      if (!hold_used && rand_words >= 120) begin
        hold_req  = 1'b1;
        hold_used = 1'b1;
      end
      // sender pause: let every owed word come out first
      if (!drain_used && rand_words >= 200) begin
        drain_used = 1'b1;
        in_valid <= 1'b0;
        while (awaited_q.size() != 0) @(posedge clk);
        @(negedge clk);
      end
      tree_episode();
    end
    in_valid <= 1'b0;
    calm = 1'b0;

    while (awaited_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("** prefix_code_tree_decoder: PASSED **");
    else
      $display("** prefix_code_tree_decoder: FAILED **");
    $finish;
  end

  // receiver: random stalls, one long counted hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      out_ready <= calm || ($urandom_range(0, 99) >= 29);
    end
  end

  // result checker, oldest expectation first
  always @(posedge clk) begin
    decode_result_t exp_word;
    if (!rst && out_valid && out_ready) begin
      if (awaited_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word sym %h status %0d",
                                  decoded_symbol, status));
      end else begin
        exp_word = awaited_q.pop_front();
        if (decoded_symbol !== exp_word.sym)
          report_mismatch($sformatf("decoded_symbol got %h want %h",
                                    decoded_symbol, exp_word.sym));
        if (status !== exp_word.st)
          report_mismatch($sformatf("status got %0d want %0d", status, exp_word.st));
      end
    end
  end

  // watchdog: ends the run when no word moves on either channel for too long
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
    $display("** prefix_code_tree_decoder: FAILED **");
    $finish;
  end

endmodule

// File: prefix_code_tree_decoder.f
hdl/pctd_pkg.sv
hdl/pctd_ram.sv
hdl/pctd_datapath.sv
hdl/pctd_ctrl.sv
hdl/prefix_code_tree_decoder.sv
sim/tb_prefix_code_tree_decoder.sv
